FILE: hdl/jsu_pkg.sv
// Package for the JSON string unescaper: item structs, phase and code names,
// and character constants. Depends on nothing; imported by the top level.
package jsu_pkg;

  typedef struct packed {
    logic       begin_req;
    logic       text_end;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_cause;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TEXT    = 3'd1,
    PH_ESC     = 3'd2,
    PH_HEX1    = 3'd3,
    PH_WANT_BS = 3'd4,
    PH_WANT_U  = 3'd5,
    PH_HEX2    = 3'd6
  } phase_e;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] CAUSE_NONE      = 3'd0;
  localparam logic [2:0] CAUSE_CONTROL   = 3'd1;
  localparam logic [2:0] CAUSE_ESCAPE    = 3'd2;
  localparam logic [2:0] CAUSE_HEX       = 3'd3;
  localparam logic [2:0] CAUSE_SURROGATE = 3'd4;
  localparam logic [2:0] CAUSE_TRUNCATED = 3'd5;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [7:0] ASCII_BS = 8'h08;
  localparam logic [7:0] ASCII_FF = 8'h0C;
  localparam logic [7:0] ASCII_LF = 8'h0A;
  localparam logic [7:0] ASCII_CR = 8'h0D;
  localparam logic [7:0] ASCII_HT = 8'h09;

  // Upper six bits of a 16-bit code unit that mark each surrogate half
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

endpackage

FILE: hdl/json_string_unescaper_utf8_unit.sv
// JSON string body unescaper with UTF-8 output, single module.
// Depends on jsu_pkg for item structs, phase enum and code constants.
//
// Usage:
//   in channel  (in_valid_i / in_ready_o / in_item_i): one body byte of a
//     JSON string per item, starting after the opening quote. Set begin_req
//     on the first byte of each string; set text_end to report that the
//     text stopped (the byte is then ignored).
//   out channel (out_valid_o / out_ready_i / out_item_o): zero to four
//     result items per input item. kind is data, close or error; last marks
//     the final result of the input item that caused it.
// Path: an accepted item sits in the input register until the result buffer
//   is free; its results are then loaded into the result buffer and offered.
// Throughput: one input item per cycle while each item yields at most one
//   result and out_ready_i is high; an item yielding n UTF-8 bytes holds the
//   result buffer while the single output port drains one byte per cycle.
// Reset: the string phase returns to idle and both registers empty; bytes
//   are ignored until a begin_req item arrives.
// Stall: when out_ready_i is low the result buffer holds its entries, the
//   input register holds its item, and in_ready_o drops once both are full.
module json_string_unescaper_utf8_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jsu_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jsu_pkg::out_item_t out_item_o
);
  import jsu_pkg::*;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // Encode a code point of up to 21 bits into UTF-8 bytes, first byte in [0]
  function automatic utf8_t enc_utf8(input logic [20:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp < 21'h80) begin
      r.n        = 3'd1;
      r.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      r.n        = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.n        = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.n        = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  // Input register
  logic     in_valid_q;
  in_item_t in_q;

  // Decoder state
  phase_e      phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  hs_q, hs_d;

  // Result buffer: cnt_q entries, idx_q is the one on offer
  logic [3:0][7:0] buf_q;
  logic [1:0]      kind_q;
  logic [2:0]      cause_q;
  logic [2:0]      cnt_q;
  logic [1:0]      idx_q;

  // Decoded results of the item in the input register
  logic [2:0]      res_n;
  logic [3:0][7:0] res_bytes;
  logic [1:0]      res_kind;
  logic [2:0]      res_cause;

  logic buf_last, buf_free, load;

  // State as seen by this item: begin_req restarts the string
  phase_e      eff_phase;
  logic [1:0]  eff_hc;
  logic [15:0] eff_acc;
  logic [9:0]  eff_hs;
  logic [7:0]  b;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] acc_new;
  logic        is_high, is_low;
  utf8_t       enc_single, enc_pair;
  logic [20:0] pair_cp;

  assign b         = in_q.in_byte;
  assign eff_phase = in_q.begin_req ? PH_TEXT : phase_q;
  assign eff_hc    = in_q.begin_req ? 2'd0 : hex_cnt_q;
  assign eff_acc   = in_q.begin_req ? 16'd0 : acc_q;
  assign eff_hs    = in_q.begin_req ? 10'd0 : hs_q;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_d = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      hex_d = b[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_new    = {eff_acc[11:0], hex_d};
  assign is_high    = (acc_new[15:10] == SURR_HIGH_TAG);
  assign is_low     = (acc_new[15:10] == SURR_LOW_TAG);
  assign pair_cp    = 21'h10000 + {1'b0, eff_hs, acc_new[9:0]};
  assign enc_single = enc_utf8({5'd0, acc_new});
  assign enc_pair   = enc_utf8(pair_cp);

  // Next state
  always_comb begin
    phase_d   = eff_phase;
    hex_cnt_d = eff_hc;
    acc_d     = eff_acc;
    hs_d      = eff_hs;
    if (eff_phase != PH_IDLE) begin
      if (in_q.text_end) begin
        phase_d = PH_IDLE;
      end else begin
        unique case (eff_phase)
          PH_TEXT: begin
            if (b == CH_QUOTE || b < CH_SPACE) phase_d = PH_IDLE;
            else if (b == CH_BSLASH) phase_d = PH_ESC;
          end
          PH_ESC: begin
            unique case (b)
              CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T:
                phase_d = PH_TEXT;
              CH_U: begin
                phase_d   = PH_HEX1;
                hex_cnt_d = 2'd0;
                acc_d     = 16'd0;
              end
              default: phase_d = PH_IDLE;
            endcase
          end
          PH_WANT_BS: phase_d = (b == CH_BSLASH) ? PH_WANT_U : PH_IDLE;
          PH_WANT_U: begin
            if (b == CH_U) begin
              phase_d   = PH_HEX2;
              hex_cnt_d = 2'd0;
              acc_d     = 16'd0;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_HEX1, PH_HEX2: begin
            if (!hex_ok) begin
              phase_d = PH_IDLE;
            end else begin
              acc_d = acc_new;
              if (eff_hc != 2'd3) begin
                hex_cnt_d = eff_hc + 2'd1;
              end else begin
                hex_cnt_d = 2'd0;
                if (eff_phase == PH_HEX1) begin
                  if (is_high) begin
                    hs_d    = acc_new[9:0];
                    phase_d = PH_WANT_BS;
                  end else begin
                    phase_d = is_low ? PH_IDLE : PH_TEXT;
                  end
                end else begin
                  phase_d = is_low ? PH_TEXT : PH_IDLE;
                end
              end
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // Results of this item
  always_comb begin
    res_n     = 3'd0;
    res_bytes = '0;
    res_kind  = KIND_DATA;
    res_cause = CAUSE_NONE;
    if (eff_phase != PH_IDLE) begin
      if (in_q.text_end) begin
        res_n = 3'd1; res_kind = KIND_ERROR; res_cause = CAUSE_TRUNCATED;
      end else begin
        unique case (eff_phase)
          PH_TEXT: begin
            if (b == CH_QUOTE) begin
              res_n = 3'd1; res_kind = KIND_CLOSE;
            end else if (b < CH_SPACE) begin
              res_n = 3'd1; res_kind = KIND_ERROR; res_cause = CAUSE_CONTROL;
            end else if (b != CH_BSLASH) begin
              res_n = 3'd1; res_bytes[0] = b;
            end
          end
          PH_ESC: begin
            res_n = 3'd1;
            unique case (b)
              CH_QUOTE, CH_BSLASH, CH_SLASH: res_bytes[0] = b;
              CH_B: res_bytes[0] = ASCII_BS;
              CH_F: res_bytes[0] = ASCII_FF;
              CH_N: res_bytes[0] = ASCII_LF;
              CH_R: res_bytes[0] = ASCII_CR;
              CH_T: res_bytes[0] = ASCII_HT;
              CH_U: res_n = 3'd0;
              default: begin
                res_kind = KIND_ERROR; res_cause = CAUSE_ESCAPE;
              end
            endcase
          end
          PH_WANT_BS: begin
            if (b != CH_BSLASH) begin
              res_n = 3'd1; res_kind = KIND_ERROR; res_cause = CAUSE_SURROGATE;
            end
          end
          PH_WANT_U: begin
            if (b != CH_U) begin
              res_n = 3'd1; res_kind = KIND_ERROR; res_cause = CAUSE_SURROGATE;
            end
          end
          PH_HEX1, PH_HEX2: begin
            if (!hex_ok) begin
              res_n = 3'd1; res_kind = KIND_ERROR; res_cause = CAUSE_HEX;
            end else if (eff_hc == 2'd3) begin
              if (eff_phase == PH_HEX1) begin
                if (is_low) begin
                  res_n = 3'd1; res_kind = KIND_ERROR; res_cause = CAUSE_SURROGATE;
                end else if (!is_high) begin
                  res_n = enc_single.n; res_bytes = enc_single.bytes;
                end
              end else if (is_low) begin
                res_n = enc_pair.n; res_bytes = enc_pair.bytes;
              end else begin
                res_n = 3'd1; res_kind = KIND_ERROR; res_cause = CAUSE_SURROGATE;
              end
            end
          end
          default: res_n = 3'd0;
        endcase
      end
    end
  end

  // Handshake: the buffer frees as its final entry is taken
  assign buf_last    = ({1'b0, idx_q} == (cnt_q - 3'd1));
  assign out_valid_o = (cnt_q != 3'd0);
  assign buf_free    = !out_valid_o || (out_ready_i && buf_last);
  assign load        = in_valid_q && buf_free;
  assign in_ready_o  = !in_valid_q || load;

  assign out_item_o.out_byte    = buf_q[idx_q];
  assign out_item_o.kind        = kind_q;
  assign out_item_o.error_cause = cause_q;
  assign out_item_o.last        = buf_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PH_IDLE;
      hex_cnt_q  <= 2'd0;
      acc_q      <= 16'd0;
      hs_q       <= 10'd0;
      cnt_q      <= 3'd0;
      idx_q      <= 2'd0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (load) begin
        // Move the item's results into the buffer and advance the phase
        phase_q   <= phase_d;
        hex_cnt_q <= hex_cnt_d;
        acc_q     <= acc_d;
        hs_q      <= hs_d;
        cnt_q     <= res_n;
        idx_q     <= 2'd0;
      end else if (out_valid_o && out_ready_i) begin
        if (buf_last) begin
          cnt_q <= 3'd0;
          idx_q <= 2'd0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_item_i;
    if (load) begin
      buf_q   <= res_bytes;
      kind_q  <= res_kind;
      cause_q <= res_cause;
    end
  end

endmodule
